// ----- hdl/bid_pkg.sv -----
// Shared types and codes for the bounded integer deque.
// Holds operation codes, status codes and fixed field widths; depends on nothing.
package bid_pkg;

	localparam int unsigned ValueW  = 32;
	localparam int unsigned OpW     = 3;
	localparam int unsigned StatusW = 2;

	typedef logic [OpW-1:0]     opcode_t;
	typedef logic [StatusW-1:0] status_t;
	typedef logic [ValueW-1:0]  value_t;

	localparam opcode_t OP_PUSH_HEAD = 3'd0;
	localparam opcode_t OP_PUSH_TAIL = 3'd1;
	localparam opcode_t OP_POP_HEAD  = 3'd2;
	localparam opcode_t OP_POP_TAIL  = 3'd3;
	localparam opcode_t OP_ROTATE    = 3'd4;
	localparam opcode_t OP_CLEAR     = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

endpackage

// ----- hdl/bounded_integer_deque.sv -----
// Top level of the bounded integer deque: ring store, pointer logic and stream ports.
// Depends on bid_pkg for operation codes, status codes and widths.
//
// Usage: each input item on the s_axis channel carries one operation. The opcode
// travels in s_axis_tuser and the value to push in s_axis_tdata. Every item gives
// exactly one result item on m_axis: status, popped value and the entry count after
// the operation. Operations are push head, push tail, pop head, pop tail, rotate
// (head entry moves to the tail) and clear.
// An accepted item passes through the stage register into the output register, where
// the receiver takes it. One item is accepted in every cycle while the result side
// keeps up. Head and count are updated at the acceptance edge; the store read is
// issued there too, and the store write (push or rotate) is done from the stage
// register when the stage moves on, with a bypass so that a read right behind a
// pending write sees the new value.
// Reset clears head, count and all valid flags; the store itself is not cleared and
// needs no clearing pass, since only written entries are ever read.
// When the receiver stalls, the output register holds its result and the stage
// register can still take one more item; after that s_axis_tready drops until the
// output register drains. Nothing is lost or repeated under any stall pattern.
module bounded_integer_deque #(
	parameter int unsigned DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// push_value [31:0]
	input  logic [31:0] s_axis_tdata,
	// opcode [2:0]
	input  logic [2:0]  s_axis_tuser,

	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// status [1:0], popped_value [33:2], entry_count [33+CW:34], zero padding above
	output logic [((2+32+$clog2(DEPTH+1)+7)/8)*8-1:0]   m_axis_tdata
);

	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH+1);
	localparam int unsigned SW    = PW + 1;
	localparam int unsigned OUT_W = bid_pkg::StatusW + bid_pkg::ValueW + CW;
	localparam int unsigned PAD_W = ((OUT_W + 7) / 8) * 8;

	// Ring store.
	bid_pkg::value_t mem [DEPTH];

	// Architectural pointer state.
	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;

	// Stage one registers.
	logic              valid_s1;
	logic              we_s1;
	logic              push_s1;
	logic              pop_s1;
	logic [PW-1:0]     wa_s1;
	bid_pkg::value_t   value_s1;
	bid_pkg::value_t   mem_rd_s1;
	logic              fwd_s1;
	bid_pkg::value_t   fwd_data_s1;
	bid_pkg::status_t  status_s1;
	logic [CW-1:0]     count_s1;

	// Output register.
	logic              out_valid_q;
	bid_pkg::status_t  out_status_q;
	bid_pkg::value_t   out_popped_q;
	logic [CW-1:0]     out_count_q;

	// Decode and pointer arithmetic.
	logic              accept;
	logic              s1_move;
	bid_pkg::opcode_t  op;
	logic              is_empty;
	logic              is_full;
	logic [SW-1:0]     sum_next;
	logic [SW-1:0]     sum_last;
	logic [PW-1:0]     tail_next;
	logic [PW-1:0]     tail_last;
	logic [PW-1:0]     head_inc;
	logic [PW-1:0]     head_dec;
	logic [PW-1:0]     rd_addr;
	logic [PW-1:0]     wr_addr;
	logic              wr_en;
	logic              pop_ok;
	logic [PW-1:0]     head_nx;
	logic [CW-1:0]     count_nx;
	bid_pkg::status_t  status_nx;
	bid_pkg::value_t   rd_sel_s1;
	bid_pkg::value_t   wdata_s1;

	assign s1_move       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_move;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op            = s_axis_tuser;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q >= CW'(DEPTH));

	// Slot after the tail and the tail slot itself, each wrapped once.
	always_comb begin
		sum_next = SW'(head_q) + SW'(count_q);
		sum_last = sum_next - SW'(1);
		tail_next = (sum_next >= SW'(DEPTH)) ? PW'(sum_next - SW'(DEPTH)) : PW'(sum_next);
		tail_last = (sum_last >= SW'(DEPTH)) ? PW'(sum_last - SW'(DEPTH)) : PW'(sum_last);
		head_inc  = (head_q == PW'(DEPTH-1)) ? '0 : head_q + PW'(1);
		head_dec  = (head_q == '0) ? PW'(DEPTH-1) : head_q - PW'(1);
	end

	always_comb begin
		head_nx   = head_q;
		count_nx  = count_q;
		status_nx = bid_pkg::ST_OK;
		rd_addr   = head_q;
		wr_addr   = tail_next;
		wr_en     = 1'b0;
		pop_ok    = 1'b0;
		case (op)
			bid_pkg::OP_PUSH_HEAD: begin
				wr_addr = head_dec;
				if (is_full) begin
					status_nx = bid_pkg::ST_FULL;
				end else begin
					wr_en    = 1'b1;
					head_nx  = head_dec;
					count_nx = count_q + CW'(1);
				end
			end
			bid_pkg::OP_PUSH_TAIL: begin
				if (is_full) begin
					status_nx = bid_pkg::ST_FULL;
				end else begin
					wr_en    = 1'b1;
					count_nx = count_q + CW'(1);
				end
			end
			bid_pkg::OP_POP_HEAD: begin
				if (is_empty) begin
					status_nx = bid_pkg::ST_EMPTY;
				end else begin
					pop_ok   = 1'b1;
					head_nx  = head_inc;
					count_nx = count_q - CW'(1);
				end
			end
			bid_pkg::OP_POP_TAIL: begin
				rd_addr = tail_last;
				if (is_empty) begin
					status_nx = bid_pkg::ST_EMPTY;
				end else begin
					pop_ok   = 1'b1;
					count_nx = count_q - CW'(1);
				end
			end
			bid_pkg::OP_ROTATE: begin
				// On a full queue the slot after the tail is the head slot itself.
				if (is_empty) begin
					status_nx = bid_pkg::ST_EMPTY;
				end else begin
					wr_en   = 1'b1;
					head_nx = head_inc;
				end
			end
			bid_pkg::OP_CLEAR: begin
				head_nx  = '0;
				count_nx = '0;
			end
			default: begin
			end
		endcase
	end

	// A rotate moves the value it read; a push writes its own value.
	assign rd_sel_s1 = fwd_s1 ? fwd_data_s1 : mem_rd_s1;
	assign wdata_s1  = push_s1 ? value_s1 : rd_sel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_nx;
				count_q <= count_nx;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Stage one payload and the bypass of the write still pending in stage one.
	always_ff @(posedge clk) begin
		if (accept) begin
			we_s1       <= wr_en;
			push_s1     <= (op == bid_pkg::OP_PUSH_HEAD) || (op == bid_pkg::OP_PUSH_TAIL);
			pop_s1      <= pop_ok;
			wa_s1       <= wr_addr;
			value_s1    <= s_axis_tdata;
			status_s1   <= status_nx;
			count_s1    <= count_nx;
			fwd_s1      <= valid_s1 && we_s1 && (wa_s1 == rd_addr);
			fwd_data_s1 <= wdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_rd_s1 <= mem[rd_addr];
		end
		if (valid_s1 && s1_move && we_s1) begin
			mem[wa_s1] <= wdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			out_status_q <= status_s1;
			out_popped_q <= pop_s1 ? rd_sel_s1 : '0;
			out_count_q  <= count_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = PAD_W'({out_count_q, out_popped_q, out_status_q});

	// The count never leaves the ring's capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	// A full report always comes with a full queue.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == bid_pkg::ST_FULL) |-> out_count_q == CW'(DEPTH))
		else $error("full status with a count below depth");

	// An empty report always comes with an empty queue.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == bid_pkg::ST_EMPTY) |-> out_count_q == '0)
		else $error("empty status with a nonzero count");

	// A nonzero popped value only follows a successful operation.
	a_popped_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_popped_q != '0) |-> out_status_q == bid_pkg::ST_OK)
		else $error("popped value on a failed operation");

	// Clear returns head and count to zero.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == bid_pkg::OP_CLEAR) |=> (count_q == '0) && (head_q == '0))
		else $error("clear left entries behind");

endmodule

// ----- dv/tb_bounded_integer_deque.sv -----
// Testbench for bounded_integer_deque: drives operation items on the input stream, predicts
// every result with a behavioral deque and checks each result item field by field.
// Depends on bid_pkg and on the bounded_integer_deque RTL.
`timescale 1ns / 100ps

module tb_bounded_integer_deque;

	localparam int unsigned DEPTH       = 64;
	localparam int unsigned CountW      = $clog2(DEPTH + 1);
	localparam int unsigned OutW        = ((2 + 32 + CountW + 7) / 8) * 8;
	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned DrainCycles = 10;

	// Opcodes six and seven have no function; the block treats them as a no-op.
	localparam bid_pkg::opcode_t OP_SPARE_6 = 3'd6;
	localparam bid_pkg::opcode_t OP_SPARE_7 = 3'd7;

	typedef struct {
		bid_pkg::status_t    status;
		bid_pkg::value_t     popped;
		logic [CountW-1:0]   count;
	} deque_result_t;

	logic            clk;
	logic            arst_n        = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [31:0]     s_axis_tdata  = '0;
	logic [2:0]      s_axis_tuser  = '0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [OutW-1:0] m_axis_tdata;

	// Behavioral copy of the deque, advanced once per accepted item.
	bid_pkg::value_t ring_store [DEPTH];
	int unsigned     ring_head  = 0;
	int unsigned     ring_count = 0;

	deque_result_t   pending_results [$];
	int unsigned     error_count = 0;
	int unsigned     cycle_count = 0;
	bit              idling_on   = 1'b1;

	bounded_integer_deque #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Performs one deque operation on the local copy and returns the result it gives.
	task automatic apply_deque_op(input bid_pkg::opcode_t op, input bid_pkg::value_t val,
			output deque_result_t res);
		res.status = bid_pkg::ST_OK;
		res.popped = '0;
		case (op)
			bid_pkg::OP_PUSH_HEAD: begin
				if (ring_count >= DEPTH) begin
					res.status = bid_pkg::ST_FULL;
				end else begin
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring_store[ring_head] = val;
					ring_count++;
				end
			end
			bid_pkg::OP_PUSH_TAIL: begin
				if (ring_count >= DEPTH) begin
					res.status = bid_pkg::ST_FULL;
				end else begin
					ring_store[(ring_head + ring_count) % DEPTH] = val;
					ring_count++;
				end
			end
			bid_pkg::OP_POP_HEAD: begin
				if (ring_count == 0) begin
					res.status = bid_pkg::ST_EMPTY;
				end else begin
					res.popped = ring_store[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end
			end
			bid_pkg::OP_POP_TAIL: begin
				if (ring_count == 0) begin
					res.status = bid_pkg::ST_EMPTY;
				end else begin
					res.popped = ring_store[(ring_head + ring_count - 1) % DEPTH];
					ring_count--;
				end
			end
			bid_pkg::OP_ROTATE: begin
				// When full, the slot after the tail is the head slot itself.
				if (ring_count == 0) begin
					res.status = bid_pkg::ST_EMPTY;
				end else begin
					ring_store[(ring_head + ring_count) % DEPTH] = ring_store[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
				end
			end
			bid_pkg::OP_CLEAR: begin
				ring_head  = 0;
				ring_count = 0;
			end
			default: begin
			end
		endcase
		res.count = CountW'(ring_count);
	endtask

	function automatic bid_pkg::value_t random_value();
		case ($urandom_range(0, 11))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Picks an operation with the given share of pushes and pops, in percent; the rest are
	// rotates, spare opcodes and, if allowed, clears.
	function automatic bid_pkg::opcode_t random_op(int unsigned push_pct, int unsigned pop_pct,
			bit allow_clear);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct) begin
			return ($urandom_range(0, 1) != 0) ? bid_pkg::OP_PUSH_TAIL : bid_pkg::OP_PUSH_HEAD;
		end
		if (roll < push_pct + pop_pct) begin
			return ($urandom_range(0, 1) != 0) ? bid_pkg::OP_POP_TAIL : bid_pkg::OP_POP_HEAD;
		end
		case ($urandom_range(0, 9))
			6:       return allow_clear ? bid_pkg::OP_CLEAR : bid_pkg::OP_ROTATE;
			7, 8:    return OP_SPARE_6;
			9:       return OP_SPARE_7;
			default: return bid_pkg::OP_ROTATE;
		endcase
	endfunction

	// Presents one item at a falling edge, waits for its acceptance and records the
	// expected result. Returns right after the accepting rising edge.
	task automatic send_op(input bid_pkg::opcode_t op, input bid_pkg::value_t val);
		deque_result_t res;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= val;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		apply_deque_op(op, val, res);
		pending_results.push_back(res);
	endtask

	// Receiver side: stalls in bursts of random length while idling is on.
	initial begin : rx_stall
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected result item, expected none, actual %0h",
					$time, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
				check_field("popped_value", want.popped, m_axis_tdata[33:2]);
				check_field("entry_count", 32'(want.count), 32'(m_axis_tdata[33+CountW:34]));
			end
		end
	end

	// Pops and rotates on an empty deque, and a clear that has nothing to clear.
	task automatic test_empty_queue();
		send_op(bid_pkg::OP_POP_HEAD, random_value());
		send_op(bid_pkg::OP_POP_TAIL, random_value());
		send_op(bid_pkg::OP_ROTATE, random_value());
		send_op(bid_pkg::OP_CLEAR, random_value());
	endtask

	// Extreme values through both ends, a rotate, and pops down past empty.
	task automatic test_extreme_values();
		send_op(bid_pkg::OP_PUSH_HEAD, 32'h7fff_ffff);
		send_op(bid_pkg::OP_PUSH_TAIL, 32'h8000_0000);
		send_op(bid_pkg::OP_PUSH_HEAD, 32'h0000_0000);
		send_op(bid_pkg::OP_PUSH_TAIL, 32'hffff_ffff);
		send_op(bid_pkg::OP_ROTATE, 32'h1234_5678);
		send_op(bid_pkg::OP_POP_HEAD, 32'h0);
		send_op(bid_pkg::OP_POP_TAIL, 32'h0);
		send_op(bid_pkg::OP_POP_HEAD, 32'h0);
		send_op(bid_pkg::OP_POP_TAIL, 32'h0);
		send_op(bid_pkg::OP_POP_HEAD, 32'h0);
	endtask

	// Spare opcodes leave the deque alone; clear drops the stored entries.
	task automatic test_spare_and_clear();
		send_op(bid_pkg::OP_PUSH_TAIL, 32'h5555_5555);
		send_op(bid_pkg::OP_PUSH_HEAD, 32'haaaa_aaaa);
		send_op(OP_SPARE_6, random_value());
		send_op(OP_SPARE_7, random_value());
		send_op(bid_pkg::OP_CLEAR, random_value());
		send_op(bid_pkg::OP_POP_HEAD, random_value());
	endtask

	// Mostly pushes until the deque is full, pushes and rotates at full, then mostly pops
	// until it is empty again.
	task automatic test_fill_and_drain();
		while (ring_count < DEPTH) begin
			send_op(random_op(85, 10, 1'b0), random_value());
		end
		send_op(bid_pkg::OP_PUSH_HEAD, random_value());
		send_op(bid_pkg::OP_PUSH_TAIL, random_value());
		repeat (3) send_op(bid_pkg::OP_ROTATE, random_value());
		while (ring_count > 0) begin
			send_op(random_op(10, 85, 1'b0), random_value());
		end
		send_op(bid_pkg::OP_ROTATE, random_value());
		send_op(bid_pkg::OP_POP_TAIL, random_value());
	endtask

	task automatic test_random_mix(input int unsigned n_items);
		repeat (n_items) send_op(random_op(45, 35, 1'b1), random_value());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_extreme_values();
		test_spare_and_clear();
		test_fill_and_drain();
		test_random_mix(120);
		test_fill_and_drain();
		idling_on = 1'b0;
		test_random_mix(60);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
